// ===== src/krt_pkg.sv =====
package krt_pkg;

  // Fixed widths of the channel fields
  localparam int CMD_W    = 1;
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 64;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 1'b0,
    CMD_LOOKUP = 1'b1
  } krt_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_KEY   = 3'd5
  } krt_status_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;   // capture the accepted word
    logic scan;  // read one entry and step the scan index
    logic act;   // decide, write the table, read the hit record
    logic load;  // move the result into the output register
  } krt_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic in_bad;
    logic scan_last;
    logic out_free;
  } krt_sts_t;

endpackage

// ===== src/krt_if.sv =====
interface krt_in_if;
  logic                         valid;
  logic                         ready;
  logic [krt_pkg::CMD_W-1:0]    command;
  logic [krt_pkg::KEY_W-1:0]    key;
  logic [krt_pkg::PAY_W-1:0]    payload;
  logic [krt_pkg::STAMP_W-1:0]  stamp;

  modport source (output valid, command, key, payload, stamp, input ready);
  modport sink   (input valid, command, key, payload, stamp, output ready);
endinterface

interface krt_out_if;
  logic                         valid;
  logic                         ready;
  logic [krt_pkg::STATUS_W-1:0] status;
  logic [krt_pkg::SLOT_W-1:0]   slot;
  logic [krt_pkg::PAY_W-1:0]    payload_out;
  logic [krt_pkg::STAMP_W-1:0]  stamp_out;

  modport source (output valid, status, slot, payload_out, stamp_out, input ready);
  modport sink   (input valid, status, slot, payload_out, stamp_out, output ready);
endinterface

// ===== src/krt_ctrl.sv =====
module krt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_ACT,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl      = '0;
    ctl.cap  = accept;
    ctl.scan = (state_r == S_SCAN);
    ctl.act  = (state_r == S_ACT);
    ctl.load = (state_r == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // a bad key skips the table entirely
          if (accept) state_r <= sts.in_bad ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_last) state_r <= S_SETTLE;
        end
        S_SETTLE: state_r <= S_ACT;
        S_ACT:    state_r <= S_FINISH;
        S_FINISH: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/krt_datapath.sv =====
module krt_datapath #(
  parameter int ENTRIES      = 16,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  krt_pkg::krt_ctl_t              ctl,
  output krt_pkg::krt_sts_t              sts,
  input  logic [krt_pkg::CMD_W-1:0]      in_command,
  input  logic [krt_pkg::KEY_W-1:0]      in_key,
  input  logic [krt_pkg::PAY_W-1:0]      in_payload,
  input  logic [krt_pkg::STAMP_W-1:0]    in_stamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [krt_pkg::STATUS_W-1:0]   out_status,
  output logic [krt_pkg::SLOT_W-1:0]     out_slot,
  output logic [krt_pkg::PAY_W-1:0]      out_payload,
  output logic [krt_pkg::STAMP_W-1:0]    out_stamp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NCHAR = (KEY_BITS + 7) / 8;

  // Key canonicalization
  logic [KEY_BITS-1:0] key_raw;
  logic [KEY_BITS-1:0] key_canon;
  logic [NCHAR-1:0]    char_nz;
  logic [NCHAR-1:0]    char_keep;

  assign key_raw = in_key[KEY_BITS-1:0];

  genvar j;
  generate
    for (j = 0; j < NCHAR; j++) begin : g_char
      localparam int HI = KEY_BITS - 1 - 8 * j;
      localparam int LO = (KEY_BITS - 8 * (j + 1) > 0) ? KEY_BITS - 8 * (j + 1) : 0;
      assign char_nz[j]          = |key_raw[HI:LO];
      assign key_canon[HI:LO]    = char_keep[j] ? key_raw[HI:LO] : '0;
    end
  endgenerate

  // keep a character only while every character above it is nonzero
  always_comb begin
    logic alive;
    alive = 1'b1;
    for (int c = 0; c < NCHAR; c++) begin
      char_keep[c] = alive;
      alive        = alive & char_nz[c];
    end
  end

  // Table storage
  logic [ENTRIES-1:0]      valid_r;
  logic [KEY_BITS-1:0]     key_mem   [ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem   [ENTRIES];
  logic [krt_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];

  // Captured word
  krt_pkg::krt_op_t            cmd_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [PAYLOAD_BITS-1:0]     pay_r;
  logic [krt_pkg::STAMP_W-1:0] stamp_r;

  // Scan state
  logic [IDX_W-1:0]    scan_idx_r;
  logic [KEY_BITS-1:0] key_q_r;
  logic [IDX_W-1:0]    q_idx_r;
  logic                q_vld_r;
  logic                q_live_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx_r;

  // Result and output
  krt_pkg::krt_status_t        res_status_r;
  logic [IDX_W-1:0]            res_idx_r;
  logic                        res_slot_en_r;
  logic                        res_found_r;
  logic [PAYLOAD_BITS-1:0]     rd_pay_r;
  logic [krt_pkg::STAMP_W-1:0] rd_stamp_r;
  logic                        out_valid_r;
  krt_pkg::krt_status_t        out_status_r;
  logic [krt_pkg::SLOT_W-1:0]  out_slot_r;
  logic [krt_pkg::PAY_W-1:0]   out_pay_r;
  logic [krt_pkg::STAMP_W-1:0] out_stamp_r;

  logic             is_update;
  logic             wr_rec;
  logic             wr_new;
  logic [IDX_W-1:0] wr_idx;
  logic             q_match;

  assign is_update = (cmd_r == krt_pkg::CMD_UPDATE);
  assign wr_rec    = ctl.act && is_update && (hit_r || free_r);
  assign wr_new    = ctl.act && is_update && !hit_r && free_r;
  assign wr_idx    = hit_r ? hit_idx_r : free_idx_r;
  assign q_match   = q_live_r && q_vld_r && (key_q_r == key_r);

  assign sts.in_bad    = !char_nz[0];
  assign sts.scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r   <= krt_pkg::krt_op_t'(in_command);
      key_r   <= key_canon;
      pay_r   <= in_payload[PAYLOAD_BITS-1:0];
      stamp_r <= in_stamp;
    end
  end

  // Memories: one write and one read port each
  always_ff @(posedge clk) begin
    if (ctl.scan) key_q_r <= key_mem[scan_idx_r];
    if (wr_new) key_mem[free_idx_r] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.act) begin
      rd_pay_r   <= pay_mem[hit_idx_r];
      rd_stamp_r <= stamp_mem[hit_idx_r];
    end
    if (wr_rec) begin
      pay_mem[wr_idx]   <= pay_r;
      stamp_mem[wr_idx] <= stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    q_idx_r <= scan_idx_r;
    q_vld_r <= valid_r[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      scan_idx_r <= '0;
      q_live_r   <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
    end else begin
      q_live_r <= ctl.scan;
      if (ctl.cap) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else begin
        if (ctl.scan) begin
          scan_idx_r <= scan_idx_r + 1'b1;
          // lowest empty slot
          if (!valid_r[scan_idx_r] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= scan_idx_r;
          end
        end
        if (q_match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= q_idx_r;
        end
      end
      if (wr_new) valid_r[free_idx_r] <= 1'b1;
    end
  end

  // Decide the result
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      res_status_r  <= krt_pkg::ST_BAD_KEY;
      res_slot_en_r <= 1'b0;
      res_found_r   <= 1'b0;
      res_idx_r     <= '0;
    end else if (ctl.act) begin
      res_idx_r <= wr_idx;
      if (!is_update) begin
        res_status_r  <= hit_r ? krt_pkg::ST_FOUND : krt_pkg::ST_NOT_FOUND;
        res_slot_en_r <= hit_r;
        res_found_r   <= hit_r;
      end else begin
        res_found_r   <= 1'b0;
        res_slot_en_r <= hit_r || free_r;
        priority if (hit_r) res_status_r <= krt_pkg::ST_UPDATED;
        else if (free_r)    res_status_r <= krt_pkg::ST_INSERTED;
        else                res_status_r <= krt_pkg::ST_FULL;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_en_r ? krt_pkg::SLOT_W'(res_idx_r) : '0;
      out_pay_r    <= res_found_r ? krt_pkg::PAY_W'(rd_pay_r) : '0;
      out_stamp_r  <= res_found_r ? rd_stamp_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_payload = out_pay_r;
  assign out_stamp   = out_stamp_r;

endmodule

// ===== src/keyed_record_table_core.sv =====
// Keyed record table: upsert and lookup over ENTRIES records.
// Words are accepted one at a time, only while idle. An update or lookup scans the key memory
// through its single read port, one entry a cycle, then decides, writes the table and reads the
// hit record, and loads the result into the output register once that register is free.
// A bad key skips the table. Reset (synchronous, rst_n low) clears all valid marks and the
// output valid flag; stored keys, payloads and stamps are not cleared.
module keyed_record_table_core #(
  parameter int ENTRIES      = 16,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  krt_in_if.sink     in_ch,
  krt_out_if.source  out_ch
);

  krt_pkg::krt_ctl_t ctl;
  krt_pkg::krt_sts_t sts;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  krt_datapath #(
    .ENTRIES      (ENTRIES),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_command  (in_ch.command),
    .in_key      (in_ch.key),
    .in_payload  (in_ch.payload),
    .in_stamp    (in_ch.stamp),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot),
    .out_payload (out_ch.payload_out),
    .out_stamp   (out_ch.stamp_out)
  );

endmodule

// ===== src/krt_checker.sv =====
module krt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [krt_pkg::STATUS_W-1:0]   out_status,
  input logic [krt_pkg::SLOT_W-1:0]     out_slot,
  input logic [krt_pkg::PAY_W-1:0]      out_payload,
  input logic [krt_pkg::STAMP_W-1:0]    out_stamp
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // one word at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // a new result never appears the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early after accept");

  // only a found record carries data; failures carry no slot either
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != krt_pkg::ST_FOUND) |->
      (out_payload == '0) && (out_stamp == '0) &&
      ((out_status == krt_pkg::ST_UPDATED) || (out_status == krt_pkg::ST_INSERTED) ||
       (out_slot == '0)))
    else $error("result fields not zero for status");

endmodule

bind keyed_record_table_core krt_checker u_krt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_slot    (out_ch.slot),
  .out_payload (out_ch.payload_out),
  .out_stamp   (out_ch.stamp_out)
);

// ===== sim/keyed_record_table_core_tb.sv =====
`timescale 1ns / 1ps

module keyed_record_table_core_tb;

  localparam int TABLE_SIZE  = 16;
  localparam int RANDOM_WORDS = 1830;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    krt_pkg::krt_status_t        status;
    logic [krt_pkg::SLOT_W-1:0]  slot;
    logic [krt_pkg::PAY_W-1:0]   payload;
    logic [krt_pkg::STAMP_W-1:0] stamp;
  } reply_t;

  // Shadow copy of the record table plus the replies it owes
  class shadow_table;
    bit                        used[TABLE_SIZE];
    bit [krt_pkg::KEY_W-1:0]   keys[TABLE_SIZE];
    bit [krt_pkg::PAY_W-1:0]   payloads[TABLE_SIZE];
    bit [krt_pkg::STAMP_W-1:0] stamps[TABLE_SIZE];
    reply_t                    pending_replies[$];
    int                        errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    // Clear every byte below the first zero character
    function bit [krt_pkg::KEY_W-1:0] trim_key(bit [krt_pkg::KEY_W-1:0] raw);
      bit [krt_pkg::KEY_W-1:0] k;
      bit                      ended;
      k = raw;
      ended = 1'b0;
      for (int b = krt_pkg::KEY_W / 8 - 1; b >= 0; b--) begin
        if (!ended && k[b*8 +: 8] == 8'd0) begin
          k = k & ~((64'd1 << (b * 8)) - 64'd1);
          ended = 1'b1;
        end
      end
      return k;
    endfunction

    function void apply_request(krt_pkg::krt_op_t op, bit [krt_pkg::KEY_W-1:0] raw_key,
                                bit [krt_pkg::PAY_W-1:0] pay,
                                bit [krt_pkg::STAMP_W-1:0] stp);
      bit [krt_pkg::KEY_W-1:0] k;
      reply_t                  r;
      int                      hit;
      int                      free_idx;
      k = trim_key(raw_key);
      r.status  = krt_pkg::ST_BAD_KEY;
      r.slot    = '0;
      r.payload = '0;
      r.stamp   = '0;
      hit = -1;
      free_idx = -1;
      if (k[krt_pkg::KEY_W-1 -: 8] != 8'd0) begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (used[i]) begin
            if (hit < 0 && keys[i] == k) hit = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (op == krt_pkg::CMD_UPDATE) begin
          if (hit >= 0) begin
            payloads[hit] = pay;
            stamps[hit] = stp;
            r.status = krt_pkg::ST_UPDATED;
            r.slot = hit[krt_pkg::SLOT_W-1:0];
          end else if (free_idx >= 0) begin
            used[free_idx] = 1'b1;
            keys[free_idx] = k;
            payloads[free_idx] = pay;
            stamps[free_idx] = stp;
            r.status = krt_pkg::ST_INSERTED;
            r.slot = free_idx[krt_pkg::SLOT_W-1:0];
          end else begin
            r.status = krt_pkg::ST_FULL;
          end
        end else begin
          if (hit >= 0) begin
            r.status = krt_pkg::ST_FOUND;
            r.slot = hit[krt_pkg::SLOT_W-1:0];
            r.payload = payloads[hit];
            r.stamp = stamps[hit];
          end else begin
            r.status = krt_pkg::ST_NOT_FOUND;
          end
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void compare_reply(logic [krt_pkg::STATUS_W-1:0] status,
                                logic [krt_pkg::SLOT_W-1:0] slot,
                                logic [krt_pkg::PAY_W-1:0] pay,
                                logic [krt_pkg::STAMP_W-1:0] stp);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word: status %0d slot %0d payload %h stamp %h",
                 $time, status, slot, pay, stp);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (slot !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
        errors++;
      end
      if (pay !== e.payload) begin
        $display("%0t: payload expected %h actual %h", $time, e.payload, pay);
        errors++;
      end
      if (stp !== e.stamp) begin
        $display("%0t: stamp expected %h actual %h", $time, e.stamp, stp);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  krt_in_if  in_ch();
  krt_out_if out_ch();

  keyed_record_table_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  shadow_table table_model = new();

  int src_idle;
  int snk_idle;
  int words_accepted;
  int hold_left;
  bit hold_done;
  int cycle_count;

  logic [krt_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
  int                        key_len[POOL_SIZE];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check the result side before noting the request taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        table_model.compare_reply(out_ch.status, out_ch.slot, out_ch.payload_out,
                                  out_ch.stamp_out);
      if (in_ch.valid && in_ch.ready) begin
        table_model.apply_request(krt_pkg::krt_op_t'(in_ch.command), in_ch.key,
                                  in_ch.payload, in_ch.stamp);
        words_accepted++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_accepted >= 1500) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle);
      end
    end
  end

  task automatic send_word(krt_pkg::krt_op_t op, logic [krt_pkg::KEY_W-1:0] k,
                           logic [krt_pkg::PAY_W-1:0] p,
                           logic [krt_pkg::STAMP_W-1:0] s);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.command = op;
    in_ch.key     = k;
    in_ch.payload = p;
    in_ch.stamp   = s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [krt_pkg::KEY_W-1:0] make_key(int len);
    logic [krt_pkg::KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++)
      k[krt_pkg::KEY_W-1-8*i -: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  function automatic logic [krt_pkg::PAY_W-1:0] rand_payload();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin
    int                        pick;
    int                        idx;
    krt_pkg::krt_op_t          op;
    logic [krt_pkg::KEY_W-1:0] k;
    logic [krt_pkg::KEY_W-1:0] junk_mask;

    in_ch.valid   = 1'b0;
    in_ch.command = krt_pkg::CMD_UPDATE;
    in_ch.key     = '0;
    in_ch.payload = '0;
    in_ch.stamp   = '0;
    rst_n = 1'b0;
    src_idle = 20;
    snk_idle = 75;
    words_accepted = 0;
    hold_left = 0;
    hold_done = 1'b0;
    cycle_count = 0;

    for (int i = 0; i < POOL_SIZE; i++) begin
      key_len[i] = $urandom_range(8, 1);
      key_pool[i] = make_key(key_len[i]);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, bad keys, extremes, string end handling
    send_word(krt_pkg::CMD_LOOKUP, 64'h4142_4344_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'h00FF_FFFF_FFFF_FFFF, '1, '1);
    send_word(krt_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, '0, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
    send_word(krt_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '1, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'h4100_A5A5_5A5A_FFFF,
              64'h0123_4567_89AB_CDEF, 32'h1234_5678);
    send_word(krt_pkg::CMD_LOOKUP, 64'h4100_0000_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'h4100_1234_0000_0001, '0, '0);
    send_word(krt_pkg::CMD_LOOKUP, 64'h4100_FFFF_FFFF_FFFF, '0, '0);
    send_word(krt_pkg::CMD_LOOKUP, 64'h41FF_0000_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'h8000_0000_0000_0001,
              64'h8000_0000_0000_0000, 32'h8000_0000);
    send_word(krt_pkg::CMD_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hA5A5_5A5A_0F0F_F0F0, 32'hDEAD_BEEF);
    send_word(krt_pkg::CMD_LOOKUP, 64'h8000_7777_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_UPDATE, 64'h0102_0304_0506_0700, '1, 32'h0000_0001);
    send_word(krt_pkg::CMD_LOOKUP, 64'h0102_0304_0506_07FF, '0, '0);
    send_word(krt_pkg::CMD_LOOKUP, 64'h0100_0000_0000_0000, '0, '0);
    send_word(krt_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        src_idle = 75;
        snk_idle = 20;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end
      pick = $urandom_range(99);
      op = krt_pkg::krt_op_t'($urandom_range(1));
      if (pick < 8) begin
        // bad key: first character zero, rest random
        k = {$urandom, $urandom};
        k[krt_pkg::KEY_W-1 -: 8] = 8'd0;
      end else if (pick < 15) begin
        k = {$urandom, $urandom};
      end else begin
        idx = $urandom_range(POOL_SIZE - 1);
        k = key_pool[idx];
        op = ($urandom_range(99) < 45) ? krt_pkg::CMD_UPDATE : krt_pkg::CMD_LOOKUP;
        // scribble below the terminator; it must not change the match
        if (key_len[idx] < 7 && $urandom_range(1) == 1) begin
          junk_mask = (64'd1 << ((7 - key_len[idx]) * 8)) - 64'd1;
          k = k | ({$urandom, $urandom} & junk_mask);
        end
      end
      send_word(op, k, rand_payload(), $urandom);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    while (table_model.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (table_model.errors == 0 && table_model.pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
